// File: src/ast_pkg.sv
// Shared types, constants and helper functions for the audible state tracker.
// Used by the front, update and top-level modules; depends on nothing else.
package ast_pkg;

   localparam int SAMPLE_WIDTH = 24;
   localparam int TIME_WIDTH = 48;
   localparam int COUNT_WIDTH = 13;
   localparam int THRESH_WIDTH = 20;
   localparam int MARGIN_WIDTH = 23;
   localparam int CSR_DATA_WIDTH = 23;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CMP_WIDTH = ((SAMPLE_WIDTH + 1 > MARGIN_WIDTH + 1) ?
                               SAMPLE_WIDTH + 1 : MARGIN_WIDTH + 1) + 1;

   localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = THRESH_WIDTH'(2048);
   localparam logic [MARGIN_WIDTH-1:0] MARGIN_RESET = MARGIN_WIDTH'(839);

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_THRESHOLD = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MARGIN = 1'b1;

   localparam logic OP_CLIENT = 1'b0;
   localparam logic OP_MIXED = 1'b1;

   typedef enum logic [1:0] {
      ST_SILENT = 2'd0,
      ST_MUSIC = 2'd1,
      ST_AUDIBLE = 2'd2
   } state_type;

   // One frame as held in the input register, end time already formed.
   typedef struct packed {
      logic op;
      logic is_music;
      logic signed [SAMPLE_WIDTH-1:0] left_sample;
      logic signed [SAMPLE_WIDTH-1:0] right_sample;
      logic first_of_buffer;
      logic last_of_buffer;
      logic [TIME_WIDTH-1:0] end_time;
   } item_type;

   typedef struct packed {
      logic valid;
      state_type audible_state;
      logic state_changed;
   } result_type;

   // True when a sample strays more than the margin from its reference.
   function automatic logic off_ref(input logic signed [SAMPLE_WIDTH-1:0] s,
                                    input logic signed [SAMPLE_WIDTH-1:0] r,
                                    input logic [MARGIN_WIDTH-1:0] m);
      logic signed [CMP_WIDTH-1:0] d;
      logic signed [CMP_WIDTH-1:0] mm;
      d = CMP_WIDTH'(s) - CMP_WIDTH'(r);
      mm = $signed(CMP_WIDTH'(m));
      return (d > mm) || (d < -mm);
   endfunction

   // End is not before t and at least thr frames past it.
   function automatic logic since_at_least(input logic [TIME_WIDTH-1:0] end_t,
                                           input logic [TIME_WIDTH-1:0] t,
                                           input logic [THRESH_WIDTH-1:0] thr);
      logic [TIME_WIDTH:0] diff;
      diff = {1'b0, end_t} - {1'b0, t};
      return !diff[TIME_WIDTH] && (diff[TIME_WIDTH-1:0] >= TIME_WIDTH'(thr));
   endfunction

endpackage

// File: src/ast_front.sv
// Input register of the audible state tracker: captures an accepted frame
// and forms the buffer end time. Depends on ast_pkg.
module ast_front (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_stall,
   input  logic req_op,
   input  logic req_is_music,
   input  logic signed [ast_pkg::SAMPLE_WIDTH-1:0] req_left_sample,
   input  logic signed [ast_pkg::SAMPLE_WIDTH-1:0] req_right_sample,
   input  logic req_first_of_buffer,
   input  logic req_last_of_buffer,
   input  logic [ast_pkg::TIME_WIDTH-1:0] req_start_time,
   input  logic [ast_pkg::COUNT_WIDTH-1:0] req_frame_count,
   input  logic item_done,
   output logic item_valid,
   output ast_pkg::item_type item
);

   logic valid_ff;
   logic valid_in;
   ast_pkg::item_type item_ff;
   ast_pkg::item_type item_in;
   logic accept;
   logic [ast_pkg::COUNT_WIDTH-1:0] count_less_one;

   assign accept = req_valid && !req_stall;

   // A zero frame count counts as one frame, so the end equals the start.
   always_comb begin
      if (req_frame_count == '0) begin
         count_less_one = '0;
      end else begin
         count_less_one = req_frame_count - ast_pkg::COUNT_WIDTH'(1);
      end
      item_in.op = req_op;
      item_in.is_music = req_is_music;
      item_in.left_sample = req_left_sample;
      item_in.right_sample = req_right_sample;
      item_in.first_of_buffer = req_first_of_buffer;
      item_in.last_of_buffer = req_last_of_buffer;
      item_in.end_time = req_start_time + ast_pkg::TIME_WIDTH'(count_less_one);
   end

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (item_done) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item = item_ff;

endmodule

// File: src/ast_update.sv
// Per-frame update of the audible state tracker: audibility test, timestamp
// bookkeeping and the three-state machine. Depends on ast_pkg.
module ast_update (
   input  logic clock,
   input  logic reset,
   input  logic item_valid,
   input  ast_pkg::item_type item,
   input  logic out_free,
   input  logic [ast_pkg::THRESH_WIDTH-1:0] threshold,
   input  logic [ast_pkg::MARGIN_WIDTH-1:0] margin,
   output logic item_done,
   output ast_pkg::result_type result
);

   ast_pkg::state_type state_ff;
   ast_pkg::state_type state_in;
   logic [ast_pkg::TIME_WIDTH-1:0] silent_ff, silent_in;
   logic [ast_pkg::TIME_WIDTH-1:0] silent_music_ff, silent_music_in;
   logic [ast_pkg::TIME_WIDTH-1:0] audible_other_ff, audible_other_in;
   logic [ast_pkg::TIME_WIDTH-1:0] audible_music_ff, audible_music_in;
   logic signed [ast_pkg::SAMPLE_WIDTH-1:0] ref_left_ff, ref_left_in;
   logic signed [ast_pkg::SAMPLE_WIDTH-1:0] ref_right_ff, ref_right_in;
   logic heard_ff, heard_in;

   logic heard_now;
   logic end_of_buffer;
   logic mixed_end;
   logic [ast_pkg::TIME_WIDTH-1:0] end_t;
   logic [ast_pkg::TIME_WIDTH-1:0] silent_eff;
   logic silent_long, music_silent_long, other_long, music_audible_long;
   logic other_now, music_now;
   ast_pkg::state_type eval_state;

   assign end_t = item.end_time;
   assign end_of_buffer = item_valid && item.last_of_buffer;
   assign mixed_end = end_of_buffer && (item.op == ast_pkg::OP_MIXED);

   // Only a mixed buffer end yields a result, so only it waits on the output.
   assign item_done = item_valid && (!mixed_end || out_free);

   // A first frame is its own reference, so it can never count as heard.
   assign heard_now = item.first_of_buffer ? 1'b0 :
                      (heard_ff ||
                       ast_pkg::off_ref(item.left_sample, ref_left_ff, margin) ||
                       ast_pkg::off_ref(item.right_sample, ref_right_ff, margin));

   assign silent_eff = (!heard_now && end_t > silent_ff) ? end_t : silent_ff;

   assign silent_long = ast_pkg::since_at_least(end_t, silent_eff, threshold);
   assign music_silent_long = ast_pkg::since_at_least(end_t, silent_music_ff, threshold);
   assign other_long = ast_pkg::since_at_least(end_t, audible_other_ff, threshold);
   assign music_audible_long = ast_pkg::since_at_least(end_t, audible_music_ff, threshold);
   assign other_now = (end_t <= audible_other_ff) && (audible_other_ff != '0);
   assign music_now = (end_t <= audible_music_ff) && (audible_music_ff != '0);

   always_comb begin
      unique case (state_ff)
         ast_pkg::ST_SILENT: begin
            if (silent_long && other_now) begin
               eval_state = ast_pkg::ST_AUDIBLE;
            end else if (music_silent_long && music_now) begin
               eval_state = ast_pkg::ST_MUSIC;
            end else begin
               eval_state = ast_pkg::ST_SILENT;
            end
         end
         ast_pkg::ST_MUSIC: begin
            if (silent_long && other_now) begin
               eval_state = ast_pkg::ST_AUDIBLE;
            end else if (other_long && music_audible_long) begin
               eval_state = ast_pkg::ST_SILENT;
            end else begin
               eval_state = ast_pkg::ST_MUSIC;
            end
         end
         ast_pkg::ST_AUDIBLE: begin
            if (other_long && music_silent_long && music_now) begin
               eval_state = ast_pkg::ST_MUSIC;
            end else if (other_long && music_audible_long) begin
               eval_state = ast_pkg::ST_SILENT;
            end else begin
               eval_state = ast_pkg::ST_AUDIBLE;
            end
         end
         default: begin
            eval_state = state_ff;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      silent_in = silent_ff;
      silent_music_in = silent_music_ff;
      audible_other_in = audible_other_ff;
      audible_music_in = audible_music_ff;
      ref_left_in = ref_left_ff;
      ref_right_in = ref_right_ff;
      heard_in = heard_ff;
      result.valid = 1'b0;
      result.audible_state = eval_state;
      result.state_changed = (eval_state != state_ff);
      if (item_done) begin
         heard_in = heard_now;
         if (item.first_of_buffer) begin
            ref_left_in = item.left_sample;
            ref_right_in = item.right_sample;
         end
         if (mixed_end) begin
            silent_in = silent_eff;
            state_in = eval_state;
            result.valid = 1'b1;
         end else if (end_of_buffer) begin
            if (item.is_music) begin
               if (heard_now) begin
                  if (end_t > audible_music_ff) begin
                     audible_music_in = end_t;
                  end
               end else if (end_t > silent_music_ff) begin
                  silent_music_in = end_t;
               end
            end else if (heard_now && end_t > audible_other_ff) begin
               audible_other_in = end_t;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ast_pkg::ST_SILENT;
         silent_ff <= '0;
         silent_music_ff <= '0;
         audible_other_ff <= '0;
         audible_music_ff <= '0;
         ref_left_ff <= '0;
         ref_right_ff <= '0;
         heard_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         silent_ff <= silent_in;
         silent_music_ff <= silent_music_in;
         audible_other_ff <= audible_other_in;
         audible_music_ff <= audible_music_in;
         ref_left_ff <= ref_left_in;
         ref_right_ff <= ref_right_in;
         heard_ff <= heard_in;
      end
   end

endmodule

// File: src/audible_state_tracker.sv
// Top level of the audible state tracker: control registers, input stage,
// update stage and result register. Depends on ast_pkg, ast_front, ast_update.
// Frames are registered in the input stage, reports in the result register.
// Throughput: one frame per cycle; a mixed buffer's last frame waits only while
// the result register holds an item that the receiver is still stalling.
// Reset (synchronous) restores the control defaults and clears the tracker state to silent.
module audible_state_tracker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_op,
   input  logic req_is_music,
   input  logic signed [ast_pkg::SAMPLE_WIDTH-1:0] req_left_sample,
   input  logic signed [ast_pkg::SAMPLE_WIDTH-1:0] req_right_sample,
   input  logic req_first_of_buffer,
   input  logic req_last_of_buffer,
   input  logic [ast_pkg::TIME_WIDTH-1:0] req_start_time,
   input  logic [ast_pkg::COUNT_WIDTH-1:0] req_frame_count,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [1:0] rsp_audible_state,
   output logic rsp_state_changed,
   input  logic csr_we,
   input  logic [ast_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ast_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);

   logic [ast_pkg::THRESH_WIDTH-1:0] threshold_ff;
   logic [ast_pkg::MARGIN_WIDTH-1:0] margin_ff;
   logic item_valid;
   logic item_done;
   logic out_free;
   ast_pkg::item_type item;
   ast_pkg::result_type result;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_state_ff;
   logic rsp_changed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= ast_pkg::THRESH_RESET;
         margin_ff <= ast_pkg::MARGIN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            ast_pkg::CSR_THRESHOLD: threshold_ff <= csr_wdata[ast_pkg::THRESH_WIDTH-1:0];
            ast_pkg::CSR_MARGIN: margin_ff <= csr_wdata[ast_pkg::MARGIN_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = item_valid && !item_done;

   ast_front u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_is_music(req_is_music),
      .req_left_sample(req_left_sample),
      .req_right_sample(req_right_sample),
      .req_first_of_buffer(req_first_of_buffer),
      .req_last_of_buffer(req_last_of_buffer),
      .req_start_time(req_start_time),
      .req_frame_count(req_frame_count),
      .item_done(item_done),
      .item_valid(item_valid),
      .item(item)
   );

   ast_update u_update (
      .clock(clock),
      .reset(reset),
      .item_valid(item_valid),
      .item(item),
      .out_free(out_free),
      .threshold(threshold_ff),
      .margin(margin_ff),
      .item_done(item_done),
      .result(result)
   );

   always_comb begin
      if (result.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         rsp_state_ff <= result.audible_state;
         rsp_changed_ff <= result.state_changed;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_audible_state = rsp_state_ff;
   assign rsp_state_changed = rsp_changed_ff;

endmodule

// File: src/ast_checker.sv
// Port-level checks for the audible state tracker, bound to the top level.
// Depends on audible_state_tracker's ports only.
module ast_checker (
   input logic clock,
   input logic reset,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic [1:0] rsp_audible_state,
   input logic rsp_state_changed
);

   // A held result keeps its contents until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_audible_state) &&
      $stable(rsp_state_changed))
      else $error("held result changed");

   // The state code three is never produced.
   a_state_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_audible_state != 2'd3)
      else $error("invalid state code");

   // The input side only waits while a result is held in the output.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

   // No result is shown right after reset.
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind audible_state_tracker ast_checker u_ast_checker (
   .clock(clock),
   .reset(reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_audible_state(rsp_audible_state),
   .rsp_state_changed(rsp_state_changed)
);

// File: tb/audible_state_tracker_tb.sv
// Self-checking testbench for audible_state_tracker: streams stereo buffers through the
// frame channel, predicts each mixed-buffer state report and checks it field by field.
// Depends on ast_pkg and the audible_state_tracker RTL only.
module audible_state_tracker_tb;

   typedef logic signed [ast_pkg::SAMPLE_WIDTH-1:0] sample_word_type;
   typedef logic [ast_pkg::TIME_WIDTH-1:0] time_word_type;

   typedef struct {
      logic op;
      logic is_music;
      sample_word_type left;
      sample_word_type right;
      logic first;
      logic last;
      time_word_type start;
      logic [ast_pkg::COUNT_WIDTH-1:0] count;
   } audio_frame_type;

   typedef struct {
      ast_pkg::state_type audible_state;
      logic state_changed;
   } state_report_type;

   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_LIMIT = 4000;
   localparam int HOLDOFF_CYCLES = 300;
   localparam longint SAMPLE_MAX = 8388607;
   localparam longint SAMPLE_MIN = -8388608;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_op = ast_pkg::OP_CLIENT;
   logic req_is_music = 1'b0;
   sample_word_type req_left_sample = '0;
   sample_word_type req_right_sample = '0;
   logic req_first_of_buffer = 1'b0;
   logic req_last_of_buffer = 1'b0;
   time_word_type req_start_time = '0;
   logic [ast_pkg::COUNT_WIDTH-1:0] req_frame_count = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_audible_state;
   logic rsp_state_changed;
   logic csr_we = 1'b0;
   logic [ast_pkg::CSR_INDEX_WIDTH-1:0] csr_index = ast_pkg::CSR_THRESHOLD;
   logic [ast_pkg::CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   // Predicted tracker state, kept in step with every accepted frame.
   logic [ast_pkg::THRESH_WIDTH-1:0] thr_q = ast_pkg::THRESH_WIDTH'(2048);
   logic [ast_pkg::MARGIN_WIDTH-1:0] margin_q = ast_pkg::MARGIN_WIDTH'(839);
   ast_pkg::state_type dev_state = ast_pkg::ST_SILENT;
   time_word_type last_mixed_silent = '0;
   time_word_type last_music_quiet = '0;
   time_word_type last_other_loud = '0;
   time_word_type last_music_loud = '0;
   sample_word_type anchor_left = '0;
   sample_word_type anchor_right = '0;
   logic buffer_loud = 1'b0;

   state_report_type pending_states[$];
   time_word_type time_base = ast_pkg::TIME_WIDTH'(30000);

   int frames_sent = 0;
   int results_checked = 0;
   int changes_seen = 0;
   int settings_used = 0;
   int mismatches = 0;

   // Sender and receiver idling controls.
   bit sender_gaps = 1'b0;
   int burst_left = 0;
   int stall_max = 0;
   int hold_request = 0;
   int hold_left = 0;
   int run_left = 0;
   bit stall_on = 1'b0;

   audible_state_tracker i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_is_music(req_is_music),
      .req_left_sample(req_left_sample),
      .req_right_sample(req_right_sample),
      .req_first_of_buffer(req_first_of_buffer),
      .req_last_of_buffer(req_last_of_buffer),
      .req_start_time(req_start_time),
      .req_frame_count(req_frame_count),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_audible_state(rsp_audible_state),
      .rsp_state_changed(rsp_state_changed),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #4000000;
      $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic bit strays(input sample_word_type s, input sample_word_type a);
      longint d;
      d = longint'(s) - longint'(a);
      return d > longint'(margin_q) || d < -longint'(margin_q);
   endfunction

   function automatic bit long_since(input time_word_type end_t, input time_word_type t);
      return end_t >= t && (end_t - t) >= ast_pkg::TIME_WIDTH'(thr_q);
   endfunction

   function automatic time_word_type later(input time_word_type a, input time_word_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic bit update_device_state(input time_word_type end_t);
      bit silent_long;
      bit music_quiet_long;
      bit other_long;
      bit music_loud_long;
      bit other_now;
      bit music_now;
      silent_long = long_since(end_t, last_mixed_silent);
      music_quiet_long = long_since(end_t, last_music_quiet);
      other_long = long_since(end_t, last_other_loud);
      music_loud_long = long_since(end_t, last_music_loud);
      other_now = end_t <= last_other_loud && last_other_loud != 0;
      music_now = end_t <= last_music_loud && last_music_loud != 0;
      if (dev_state != ast_pkg::ST_AUDIBLE && silent_long && other_now) begin
         dev_state = ast_pkg::ST_AUDIBLE;
         return 1'b1;
      end
      if (((dev_state == ast_pkg::ST_SILENT && music_quiet_long) ||
           (dev_state == ast_pkg::ST_AUDIBLE && other_long && music_quiet_long)) &&
          music_now) begin
         dev_state = ast_pkg::ST_MUSIC;
         return 1'b1;
      end
      if (dev_state != ast_pkg::ST_SILENT && other_long && music_loud_long) begin
         dev_state = ast_pkg::ST_SILENT;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void track_frame(input audio_frame_type f);
      time_word_type end_t;
      logic [ast_pkg::COUNT_WIDTH-1:0] n;
      bit changed;
      if (f.first) begin
         anchor_left = f.left;
         anchor_right = f.right;
         buffer_loud = 1'b0;
      end
      if (strays(f.left, anchor_left) || strays(f.right, anchor_right))
         buffer_loud = 1'b1;
      if (!f.last)
         return;
      // A zero frame count counts as one frame; the end time wraps at the time width.
      n = (f.count == 0) ? ast_pkg::COUNT_WIDTH'(1) : f.count;
      end_t = f.start + ast_pkg::TIME_WIDTH'(n) - ast_pkg::TIME_WIDTH'(1);
      if (f.op == ast_pkg::OP_CLIENT) begin
         if (f.is_music) begin
            if (buffer_loud)
               last_music_loud = later(last_music_loud, end_t);
            else
               last_music_quiet = later(last_music_quiet, end_t);
         end else if (buffer_loud) begin
            last_other_loud = later(last_other_loud, end_t);
         end
         return;
      end
      if (!buffer_loud)
         last_mixed_silent = later(last_mixed_silent, end_t);
      changed = update_device_state(end_t);
      pending_states.push_back('{dev_state, changed});
   endfunction

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin
      state_report_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_states.size() == 0) begin
            $error("state report with no mixed buffer outstanding");
            mismatches++;
         end else begin
            exp_r = pending_states.pop_front();
            results_checked++;
            if (exp_r.state_changed)
               changes_seen++;
            if (rsp_audible_state !== exp_r.audible_state) begin
               $error("audible_state: expected %0d, actual %0d",
                      exp_r.audible_state, rsp_audible_state);
               mismatches++;
            end
            if (rsp_state_changed !== exp_r.state_changed) begin
               $error("state_changed: expected %0d, actual %0d",
                      exp_r.state_changed, rsp_state_changed);
               mismatches++;
            end
         end
      end
   end

   // Receiver: alternating stall and free runs, overridden by a requested hold-off.
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         stall_on = 1'b1;
         run_left = 0;
         rsp_stall <= 1'b1;
      end else if (run_left != 0) begin
         run_left--;
      end else begin
         stall_on = !stall_on && stall_max != 0;
         run_left = stall_on ? $urandom_range(1, stall_max) : $urandom_range(0, 12);
         rsp_stall <= stall_on;
      end
   end

   // ---------------------------------------------------------------- stimulus helpers

   function automatic sample_word_type clip(input longint v);
      if (v > SAMPLE_MAX)
         v = SAMPLE_MAX;
      if (v < SAMPLE_MIN)
         v = SAMPLE_MIN;
      return sample_word_type'(v);
   endfunction

   // Moves away from the anchor by more than the margin, toward the roomier side.
   function automatic sample_word_type push_off(input sample_word_type a);
      longint step;
      step = longint'(margin_q) + 1 + longint'($urandom_range(0, 15));
      return (a >= 0) ? clip(longint'(a) - step) : clip(longint'(a) + step);
   endfunction

   // Stays within the margin; now and then lands exactly on its edge.
   function automatic sample_word_type stay_near(input sample_word_type a);
      int span;
      span = (margin_q > 300) ? 300 : int'(margin_q);
      if ($urandom_range(0, 4) == 0)
         return $urandom_range(0, 1) ? clip(longint'(a) + longint'(margin_q))
                                     : clip(longint'(a) - longint'(margin_q));
      return clip(longint'(a) + longint'($urandom_range(0, 2 * span)) - longint'(span));
   endfunction

   function automatic audio_frame_type frame_of(input logic op, input logic music,
                                                input longint l, input longint r,
                                                input logic first, input logic last,
                                                input time_word_type start,
                                                input int count);
      audio_frame_type f;
      f.op = op;
      f.is_music = music;
      f.left = sample_word_type'(l);
      f.right = sample_word_type'(r);
      f.first = first;
      f.last = last;
      f.start = start;
      f.count = ast_pkg::COUNT_WIDTH'(count);
      return f;
   endfunction

   task automatic offer_frame(input audio_frame_type f);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (sender_gaps) begin
            gap = $urandom_range(1, 6);
            repeat (gap) begin
               @(negedge clock);
               req_valid <= 1'b0;
            end
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_op <= f.op;
      req_is_music <= f.is_music;
      req_left_sample <= f.left;
      req_right_sample <= f.right;
      req_first_of_buffer <= f.first;
      req_last_of_buffer <= f.last;
      req_start_time <= f.start;
      req_frame_count <= f.count;
      do
         @(posedge clock);
      while (req_stall);
      track_frame(f);
      frames_sent++;
   endtask

   task automatic wait_for_results();
      int waited;
      waited = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_states.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_states.size() != 0) begin
         $error("%0d state reports never arrived", pending_states.size());
         mismatches += pending_states.size();
         pending_states.delete();
      end
      // Client frames give no report, so let the pipeline empty before going on.
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [ast_pkg::CSR_INDEX_WIDTH-1:0] idx,
                                 input logic [ast_pkg::CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx == ast_pkg::CSR_THRESHOLD)
         thr_q = value[ast_pkg::THRESH_WIDTH-1:0];
      else
         margin_q = value[ast_pkg::MARGIN_WIDTH-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_setting(input logic [ast_pkg::CSR_DATA_WIDTH-1:0] thr,
                                input logic [ast_pkg::CSR_DATA_WIDTH-1:0] margin);
      wait_for_results();
      write_register(ast_pkg::CSR_THRESHOLD, thr);
      write_register(ast_pkg::CSR_MARGIN, margin);
      settings_used++;
   endtask

   // One buffer of one to four frames; a loud buffer strays on one of its later frames.
   task automatic send_buffer(input logic op, input logic music, input bit loud,
                              input time_word_type start,
                              input logic [ast_pkg::COUNT_WIDTH-1:0] count);
      int frames;
      int loud_at;
      bit loud_left;
      sample_word_type a_l;
      sample_word_type a_r;
      audio_frame_type f;
      frames = loud ? $urandom_range(2, 4) : $urandom_range(1, 4);
      loud_at = $urandom_range(1, frames > 1 ? frames - 1 : 1);
      loud_left = bit'($urandom_range(0, 1));
      a_l = sample_word_type'($urandom);
      a_r = sample_word_type'($urandom);
      for (int i = 0; i < frames; i++) begin
         f.op = op;
         f.is_music = (op == ast_pkg::OP_CLIENT) ? music : logic'($urandom_range(0, 1));
         f.first = (i == 0);
         f.last = (i == frames - 1);
         f.start = start;
         f.count = count;
         if (i == 0) begin
            f.left = a_l;
            f.right = a_r;
         end else begin
            f.left = (loud && i == loud_at && loud_left) ? push_off(a_l) : stay_near(a_l);
            f.right = (loud && i == loud_at && !loud_left) ? push_off(a_r) : stay_near(a_r);
         end
         offer_frame(f);
      end
   endtask

   // Client buffers around one stretch of time, then the mixed buffer for it.
   task automatic send_round();
      logic [ast_pkg::COUNT_WIDTH-1:0] n;
      int clients;
      n = ($urandom_range(0, 9) == 0) ? ast_pkg::COUNT_WIDTH'($urandom_range(1, 4096))
                                      : ast_pkg::COUNT_WIDTH'($urandom_range(1, 64));
      clients = $urandom_range(0, 2);
      repeat (clients)
         send_buffer(ast_pkg::OP_CLIENT, logic'($urandom_range(0, 1)),
                     bit'($urandom_range(0, 1)),
                     time_base + ast_pkg::TIME_WIDTH'($urandom_range(0, 3)), n);
      send_buffer(ast_pkg::OP_MIXED, 1'b0, bit'($urandom_range(0, 1)), time_base, n);
      time_base += ast_pkg::TIME_WIDTH'(n);
      if ($urandom_range(0, 4) == 0)
         time_base += ast_pkg::TIME_WIDTH'($urandom_range(0, 3000));
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed_cases();
      // Quiet mixed frame at time zero, under the reset register values.
      offer_frame(frame_of(ast_pkg::OP_MIXED, 1'b0, 0, 0, 1'b1, 1'b1, 0, 1));
      // Client buffer that touches the margin exactly, then crosses it by one.
      offer_frame(frame_of(ast_pkg::OP_CLIENT, 1'b0, 0, 0, 1'b1, 1'b0, 3000, 100));
      offer_frame(frame_of(ast_pkg::OP_CLIENT, 1'b0, 839, -839, 1'b0, 1'b0, 3000, 100));
      offer_frame(frame_of(ast_pkg::OP_CLIENT, 1'b0, 0, -840, 1'b0, 1'b1, 3000, 100));
      // Full-scale samples on a loud mixed buffer: silent goes to audible.
      offer_frame(frame_of(ast_pkg::OP_MIXED, 1'b0, SAMPLE_MAX, SAMPLE_MIN, 1'b1, 1'b0,
                           3000, 100));
      offer_frame(frame_of(ast_pkg::OP_MIXED, 1'b0, SAMPLE_MIN, SAMPLE_MAX, 1'b0, 1'b1,
                           3000, 100));
      // Quiet music, then a quiet non-music buffer that changes no time at all.
      offer_frame(frame_of(ast_pkg::OP_CLIENT, 1'b1, 100, 100, 1'b1, 1'b1, 3100, 16));
      offer_frame(frame_of(ast_pkg::OP_CLIENT, 1'b0, 5, 5, 1'b1, 1'b0,
                           {ast_pkg::TIME_WIDTH{1'b1}}, 8191));
      offer_frame(frame_of(ast_pkg::OP_CLIENT, 1'b0, 844, -834, 1'b0, 1'b1,
                           {ast_pkg::TIME_WIDTH{1'b1}}, 8191));
      // Loud music over the largest buffer, then audible drops to music only.
      offer_frame(frame_of(ast_pkg::OP_CLIENT, 1'b1, -100, 0, 1'b1, 1'b0, 6000, 4096));
      offer_frame(frame_of(ast_pkg::OP_CLIENT, 1'b1, -940, 0, 1'b0, 1'b1, 6000, 4096));
      offer_frame(frame_of(ast_pkg::OP_MIXED, 1'b0, 0, 0, 1'b1, 1'b0, 6000, 4096));
      offer_frame(frame_of(ast_pkg::OP_MIXED, 1'b0, 0, 1000, 1'b0, 1'b1, 6000, 4096));
      // Zero frame count ends the buffer at its start; music only goes silent.
      offer_frame(frame_of(ast_pkg::OP_MIXED, 1'b0, 0, 0, 1'b1, 1'b0, 20000, 0));
      offer_frame(frame_of(ast_pkg::OP_MIXED, 1'b0, 2000, 0, 1'b0, 1'b1, 20000, 0));
      // Last frame with no first frame, measured against the held anchors,
      // and an end time that wraps past the top of the time range.
      offer_frame(frame_of(ast_pkg::OP_MIXED, 1'b0, SAMPLE_MIN, SAMPLE_MIN, 1'b0, 1'b1,
                           {ast_pkg::TIME_WIDTH{1'b1}}, 2));
      offer_frame(frame_of(ast_pkg::OP_MIXED, 1'b1, 0, 0, 1'b1, 1'b1, 25000, 1));
      offer_frame(frame_of(ast_pkg::OP_MIXED, 1'b1, 1, 1, 1'b1, 1'b0,
                           48'hAAAA_AAAA_AAAA, 1));
      offer_frame(frame_of(ast_pkg::OP_MIXED, 1'b1, 1, 900, 1'b0, 1'b1,
                           48'hAAAA_AAAA_AAAA, 1));
      wait_for_results();
   endtask

   task automatic test_register_settings();
      logic [ast_pkg::CSR_DATA_WIDTH-1:0] thr_list[7];
      logic [ast_pkg::CSR_DATA_WIDTH-1:0] margin_list[7];
      int goal;
      // Threshold bits above the register width must be dropped by the block.
      thr_list = '{23'd0, 23'd16, 23'd2048, 23'h7FFFFF, 23'd64, 23'd300, 23'd2048};
      margin_list = '{23'd0, 23'd839, 23'h7FFFFF, 23'd2500, 23'd200, 23'd5, 23'd839};
      margin_list[3] = ast_pkg::CSR_DATA_WIDTH'($urandom_range(0, 5000));
      thr_list[5] = ast_pkg::CSR_DATA_WIDTH'($urandom_range(0, 600));
      for (int p = 0; p < 7; p++) begin
         apply_setting(thr_list[p], margin_list[p]);
         sender_gaps = (p != 1);
         stall_max = (p == 1) ? 0 : $urandom_range(2, 20);
         goal = frames_sent + 80;
         while (frames_sent < goal)
            send_round();
      end
      wait_for_results();
   endtask

   task automatic test_receiver_holdoff();
      sender_gaps = 1'b0;
      stall_max = 6;
      @(posedge clock);
      hold_request = HOLDOFF_CYCLES;
      // The sender keeps offering while the receiver is held off, so the block backs up.
      repeat (40) begin
         send_buffer(ast_pkg::OP_MIXED, 1'b0, bit'($urandom_range(0, 1)), time_base,
                     ast_pkg::COUNT_WIDTH'(8));
         time_base += ast_pkg::TIME_WIDTH'(8);
      end
      wait_for_results();
      sender_gaps = 1'b1;
      repeat (8)
         send_round();
      wait_for_results();
   endtask

   // Broken sequences: random flags, full-scale samples, counts beyond the buffer size.
   task automatic test_broken_sequences();
      audio_frame_type f;
      sender_gaps = 1'b1;
      stall_max = 10;
      repeat (170) begin
         f.op = logic'($urandom_range(0, 1));
         f.is_music = logic'($urandom_range(0, 1));
         f.left = sample_word_type'($urandom);
         f.right = sample_word_type'($urandom);
         f.first = ($urandom_range(0, 2) == 0);
         f.last = ($urandom_range(0, 2) == 0);
         f.start = time_base + ast_pkg::TIME_WIDTH'($urandom_range(0, 2000));
         f.count = ast_pkg::COUNT_WIDTH'($urandom_range(0, 8191));
         offer_frame(f);
      end
      time_base += ast_pkg::TIME_WIDTH'(12000);
      wait_for_results();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_register_settings();
      test_receiver_holdoff();
      test_broken_sequences();
      $display("Sent %0d frames over %0d register settings; checked %0d state reports,",
               frames_sent, settings_used, results_checked);
      $display("%0d of which changed the device state.", changes_seen);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
